/* rtl/core/ukia_pkg.sv */
// Package: sizes, controller states and control/status structs of the unique key index assigner.
package ukia_pkg;

  localparam int MAX_UNIQUE  = 64;
  localparam int KEY_W       = 64;
  localparam int IDX_W       = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int CNT_W       = $clog2(MAX_UNIQUE + 1);
  localparam int WIDE_W      = 16;
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_CNT_W   = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic latch_hit;
    logic latch_miss;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/unique_key_index_assigner_unit.sv */
// Top level: unique key index assigner, dense index per 64-bit key in order of first appearance.
// Flow: a key is accepted in ST_IDLE; in ST_SCAN the scan reads one stored key per cycle
// from the key RAM and compares it until a hit or the end of the table; ST_DONE then commits
// the output word. A new key is accepted only after the previous word is committed, and the
// commit waits while the output word still held is not taken by m_axis_tready_i.
// Reset: entry count cleared, output empty; key RAM contents are not cleared.
module unique_key_index_assigner_unit
  import ukia_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [63:0] key
  input  logic                   s_axis_tuser_i,   // [0] batch_start
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [5:0] index, [6] is_new,
                                                   // [7] overflow, [14:8] unique_count
);

  cmd_t    cmd;
  status_t status;

  ukia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ukia_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .key_i         (s_axis_tdata_i[KEY_W-1:0]),
    .batch_start_i (s_axis_tuser_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

/* rtl/core/ukia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ukia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ukia_dp.sv */
// Datapath: key store, sequential compare scan, entry count and output word register.
module ukia_dp
  import ukia_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic [KEY_W-1:0]       key_i,
  input  logic                   batch_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [CNT_W-1:0] res_idx_q;
  logic             res_new_q, res_ovf_q;
  logic             out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic             out_new_q, out_ovf_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;

  logic             issue;
  logic             full;
  logic [KEY_W-1:0] rdata;
  logic [CNT_W-1:0] cnt_next;
  logic [WIDE_W-1:0] idx_wide, cnt_wide;

  assign full  = (cnt_q == CNT_W'(MAX_UNIQUE));
  assign issue = cmd_i.scan && (ptr_q != cnt_q);

  ukia_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_UNIQUE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && res_new_q),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign status_o.hit       = cmp_vld_q && (rdata == key_q);
  assign status_o.scan_done = !cmp_vld_q && (ptr_q == cnt_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign cnt_next = cnt_q + CNT_W'(res_new_q);

  always_comb begin
    ptr_d       = ptr_q;
    cmp_vld_d   = issue;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      ptr_d     = '0;
      cmp_vld_d = 1'b0;
      if (batch_start_i) begin
        cnt_d = '0;
      end
    end else if (issue) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.commit) begin
      cnt_d       = cnt_next;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idx_wide = WIDE_W'(res_idx_q);
  assign cnt_wide = WIDE_W'(cnt_next);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
    end
    if (issue) begin
      cmp_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.latch_hit) begin
      res_idx_q <= CNT_W'(cmp_idx_q);
      res_new_q <= 1'b0;
      res_ovf_q <= 1'b0;
    end else if (cmd_i.latch_miss) begin
      res_idx_q <= full ? '0 : cnt_q;
      res_new_q <= !full;
      res_ovf_q <= full;
    end
    if (cmd_i.commit) begin
      out_idx_q <= idx_wide[OUT_IDX_W-1:0];
      out_new_q <= res_new_q;
      out_ovf_q <= res_ovf_q;
      out_cnt_q <= cnt_wide[OUT_CNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_cnt_q, out_ovf_q, out_new_q, out_idx_q};

endmodule

/* rtl/core/ukia_ctrl.sv */
// Controller: sequences accept, key store scan, result latch and output commit.
module ukia_ctrl
  import ukia_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan       = 1'b1;
        cmd_o.latch_hit  = status_i.hit;
        cmd_o.latch_miss = !status_i.hit && status_i.scan_done;
      end
      ST_DONE: begin
        cmd_o.commit = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
